>>> rtl/assert_macros.svh
// Assertion macros for the RTL of the challenge mixer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/cmm_pkg.sv
// Types, constants and the Mersenne-31 reduction used by the challenge mixer.
package cmm_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned RES_W    = 31;
  localparam int unsigned PROD_W   = 63;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [RES_W-1:0]  MOD_M   = 31'h7FFF_FFFF;
  localparam logic [RES_W-1:0]  MIX_MUL = 31'h0E79_A9C1;

  localparam logic [CFG_IDX_W-1:0] CFG_DIGEST_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIGEST_B = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIGEST_C = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIGEST_D = 2'd3;

  typedef struct packed {
    logic [WORD_W-1:0] even_word;
    logic [WORD_W-1:0] odd_word;
    logic              last_pair;
  } in_t;

  typedef struct packed {
    logic [WORD_W-1:0] answer_a;
    logic [WORD_W-1:0] answer_b;
    logic [WORD_W-1:0] answer_c;
    logic [WORD_W-1:0] answer_d;
  } out_t;

  // Reduces a value below 2^63 modulo 2^31-1 by folding the upper bits twice.
  function automatic logic [RES_W-1:0] mod_m(input logic [PROD_W-1:0] x);
    logic [RES_W+1:0] s1;
    logic [RES_W:0]   s2;
    logic [RES_W:0]   s3;
    s1 = {2'b00, x[RES_W-1:0]} + {1'b0, x[PROD_W-1:RES_W]};
    s2 = {1'b0, s1[RES_W-1:0]} + {{(RES_W-1){1'b0}}, s1[RES_W+1:RES_W]};
    s3 = s2 - {1'b0, MOD_M};
    if (s2 >= {1'b0, MOD_M}) begin
      return s3[RES_W-1:0];
    end
    return s2[RES_W-1:0];
  endfunction

endpackage

>>> rtl/challenge_mix_mod_mersenne31.sv
// Challenge mixer: folds word pairs into two accumulators modulo 2^31-1.
//
// Input channel: in_valid_i / in_stall_o carry one pair of challenge words and
// a flag that marks the last pair. A transfer happens on a rising edge with
// valid high and stall low. Output channel: out_valid_o / out_stall_i carry
// the four answer words, produced only for a last pair.
// Each pair runs through one shared 32x31-bit multiply-add and one shared
// Mersenne-31 reduction under a small sequencer. The input is stalled while
// the sequencer runs MUL1, RED1, MUL2, RED2, ADD3, MUL3, RED3, HIGH and, for a
// last pair, FINL and FINH, so a new pair is taken only once the previous one
// is done. For a last pair the answer is loaded into the output register in FINH.
// A result may wait in the output register while the next pair is taken; if
// it has not been taken when the next answer is ready, the sequencer waits in
// its final step until the output side accepts.
// Configuration writes land on cfg_we_i with cfg_idx_i selecting the digest
// word. Reset clears the digest words, the accumulators and all control state.
module challenge_mix_mod_mersenne31 (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  cmm_pkg::in_t                     in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output cmm_pkg::out_t                    out_data_o,
  input  logic                             cfg_we_i,
  input  logic [cmm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [cmm_pkg::WORD_W-1:0]       cfg_data_i
);
  import cmm_pkg::*;

  `include "assert_macros.svh"

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MUL1 = 4'd1;
  localparam logic [3:0] ST_RED1 = 4'd2;
  localparam logic [3:0] ST_MUL2 = 4'd3;
  localparam logic [3:0] ST_RED2 = 4'd4;
  localparam logic [3:0] ST_ADD3 = 4'd5;
  localparam logic [3:0] ST_MUL3 = 4'd6;
  localparam logic [3:0] ST_RED3 = 4'd7;
  localparam logic [3:0] ST_HIGH = 4'd8;
  localparam logic [3:0] ST_FINL = 4'd9;
  localparam logic [3:0] ST_FINH = 4'd10;

  logic [3:0]        state_q, state_d;
  logic [WORD_W-1:0] dig_a_q, dig_b_q, dig_c_q, dig_d_q;
  logic [WORD_W-1:0] ev_q, od_q;
  logic              last_q;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [RES_W-1:0]  t_q, t2_q, fl_q;
  logic [RES_W-1:0]  low_q, high_q;
  logic              out_valid_q;
  out_t              out_q, out_d;

  logic [WORD_W-1:0] mul_a;
  logic [RES_W-1:0]  mul_b, mul_c;
  logic [PROD_W-1:0] red_in;
  logic [RES_W-1:0]  red_out;
  logic              in_fire, out_fire, out_load;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_fire    = out_valid_q && !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  // The answer register can take a new value once it is empty or being drained.
  assign out_load    = (state_q == ST_FINH) && (!out_valid_q || !out_stall_i);

  // Operand selection for the shared multiply-add unit.
  always_comb begin
    mul_a = ev_q;
    mul_b = MIX_MUL;
    mul_c = '0;
    case (state_q)
      ST_MUL2: begin
        mul_a = {1'b0, t_q} + {1'b0, low_q};
        mul_b = dig_a_q[RES_W-1:0];
        mul_c = dig_b_q[RES_W-1:0];
      end
      ST_MUL3: begin
        mul_a = {1'b0, t_q};
        mul_b = dig_c_q[RES_W-1:0];
        mul_c = dig_d_q[RES_W-1:0];
      end
      default: begin
        mul_a = ev_q;
        mul_b = MIX_MUL;
        mul_c = '0;
      end
    endcase
  end

  assign prod_d = PROD_W'(mul_a) * PROD_W'(mul_b) + PROD_W'(mul_c);

  // Operand selection for the shared modular reduction.
  always_comb begin
    case (state_q)
      ST_ADD3: red_in = PROD_W'(od_q) + PROD_W'(t2_q);
      ST_HIGH: red_in = PROD_W'(high_q) + PROD_W'(t2_q) + PROD_W'(low_q);
      ST_FINL: red_in = PROD_W'(low_q) + PROD_W'(dig_b_q[RES_W-1:0]);
      ST_FINH: red_in = PROD_W'(high_q) + PROD_W'(dig_d_q[RES_W-1:0]);
      default: red_in = prod_q;
    endcase
  end

  assign red_out = mod_m(red_in);

  always_comb begin
    out_d.answer_a = dig_a_q ^ {1'b0, fl_q};
    out_d.answer_b = dig_b_q ^ {1'b0, red_out};
    out_d.answer_c = dig_c_q ^ {1'b0, fl_q};
    out_d.answer_d = dig_d_q ^ {1'b0, red_out};
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) state_d = ST_MUL1;
      end
      ST_MUL1: state_d = ST_RED1;
      ST_RED1: state_d = ST_MUL2;
      ST_MUL2: state_d = ST_RED2;
      ST_RED2: state_d = ST_ADD3;
      ST_ADD3: state_d = ST_MUL3;
      ST_MUL3: state_d = ST_RED3;
      ST_RED3: state_d = ST_HIGH;
      ST_HIGH: state_d = last_q ? ST_FINL : ST_IDLE;
      ST_FINL: state_d = ST_FINH;
      ST_FINH: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      low_q       <= '0;
      high_q      <= '0;
      dig_a_q     <= '0;
      dig_b_q     <= '0;
      dig_c_q     <= '0;
      dig_d_q     <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DIGEST_A: dig_a_q <= cfg_data_i;
          CFG_DIGEST_B: dig_b_q <= cfg_data_i;
          CFG_DIGEST_C: dig_c_q <= cfg_data_i;
          CFG_DIGEST_D: dig_d_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == ST_RED3) low_q <= red_out;
      if (state_q == ST_HIGH) high_q <= red_out;
      if (out_load) begin
        low_q       <= '0;
        high_q      <= '0;
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ev_q   <= in_data_i.even_word;
      od_q   <= in_data_i.odd_word;
      last_q <= in_data_i.last_pair;
    end
    if ((state_q == ST_MUL1) || (state_q == ST_MUL2) || (state_q == ST_MUL3)) begin
      prod_q <= prod_d;
    end
    if ((state_q == ST_RED1) || (state_q == ST_ADD3)) t_q <= red_out;
    if (state_q == ST_RED2) t2_q <= red_out;
    if (state_q == ST_FINL) fl_q <= red_out;
    if (out_load) out_q <= out_d;
  end

  `ASSERT_NEXT(a_accept_starts, in_fire, state_q == ST_MUL1, "accepted pair did not start work")
  `ASSERT_SAME(a_low_reduced, 1'b1, low_q != MOD_M, "low accumulator not reduced")
  `ASSERT_SAME(a_high_reduced, 1'b1, high_q != MOD_M, "high accumulator not reduced")
  `ASSERT_NEXT(a_final_clears, out_load,
               out_valid_q && (low_q == '0) && (high_q == '0) && (state_q == ST_IDLE),
               "final step did not post answer and clear accumulators")
  `ASSERT_SAME(a_fin_needs_last, (state_q == ST_FINL) || (state_q == ST_FINH), last_q,
               "finalization entered for a pair that is not last")

endmodule
